// ===== rtl/tle_pkg.sv =====
package tle_pkg;

	localparam int KeptPayloadBytes = 4;
	localparam int MaxOut = 14;
	localparam int CmdDepth = 2;

	localparam logic [7:0] T_GENERAL           = 8'h11;
	localparam logic [7:0] T_I_AM_MASTER       = 8'h22;
	localparam logic [7:0] T_I_AM_NOT_MASTER   = 8'h33;
	localparam logic [7:0] T_ARE_YOU_MASTER    = 8'h44;
	localparam logic [7:0] T_NEED_NID          = 8'h55;
	localparam logic [7:0] T_REPORT_HID        = 8'h66;
	localparam logic [7:0] T_HERE_IS_MY_NID    = 8'h88;
	localparam logic [7:0] T_HERE_IS_YOUR_NID  = 8'hAA;
	localparam logic [7:0] T_REPORT_NEIGHBOURS = 8'h99;
	localparam logic [7:0] T_CHANGE_HW_ID      = 8'hBB;
	localparam logic [7:0] T_RESET_NID         = 8'hCC;

	localparam logic [1:0] FUNC_SERIAL = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_RADIO  = 2'd2;

	localparam logic [1:0] REG_ASK_MASTER = 2'd0;
	localparam logic [1:0] REG_ASK_ID     = 2'd1;
	localparam logic [1:0] REG_TILE_KIND  = 2'd2;
	localparam logic [1:0] REG_UID        = 2'd3;

	localparam logic [15:0] ASK_MASTER_RST = 16'd100;
	localparam logic [15:0] ASK_ID_RST     = 16'd750;
	localparam logic [7:0]  TILE_KIND_RST  = 8'd2;
	localparam logic [31:0] UID_RST        = 32'd1675286374;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] byte_value;
		logic       pin_level;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
		logic       led_lit;
	} out_item_t;

	// frame kinds the back end can emit
	typedef enum logic [2:0] {
		FR_HDR0,   // header only, no payload
		FR_NID,    // here-is-my-nid, one byte
		FR_HID,    // hardware id report
		FR_NEIGH,  // neighbour report
		FR_GEN     // general frame with one byte
	} frame_kind_t;

	typedef struct packed {
		logic        valid;
		frame_kind_t kind;
		logic [7:0]  ftype;
		logic [7:0]  target;
		logic [7:0]  sender;
		logic [7:0]  data;
	} frame_desc_t;

	// one item's worth of output work: up to three frames
	typedef struct packed {
		frame_desc_t f0;
		frame_desc_t f1;
		frame_desc_t f2;
		logic [31:0] uid;
		logic [7:0]  kind_byte;
		logic        led;
	} cmd_t;

	function automatic logic [3:0] frame_len(frame_kind_t k);
		case (k)
			FR_HDR0:  frame_len = 4'd4;
			FR_NID:   frame_len = 4'd5;
			FR_HID:   frame_len = 4'd9;
			FR_NEIGH: frame_len = 4'd8;
			FR_GEN:   frame_len = 4'd5;
			default:  frame_len = 4'd4;
		endcase
	endfunction

endpackage

// ===== rtl/tle_front.sv =====
module tle_front #(
	parameter int KEPT = tle_pkg::KeptPayloadBytes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tle_pkg::in_item_t  in_item,
	output logic               in_stall,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	output logic [31:0]        cfg_rdata_0,
	output logic [31:0]        cfg_rdata_1,
	output logic [31:0]        cfg_rdata_2,
	output logic [31:0]        cfg_rdata_3,
	output logic               cmd_push,
	output tle_pkg::cmd_t      cmd,
	input  logic               cmd_full
);
	localparam int CW = $clog2(KEPT);

	logic [15:0] ask_master_q, ask_id_q;
	logic [7:0]  tile_kind_q;
	logic [31:0] factory_q, hw_uid_q;
	logic [2:0]  phase_q;
	logic [7:0]  hdr_type_q, hdr_target_q, hdr_length_q, pcount_q;
	logic [7:0]  head_q [KEPT];
	logic [7:0]  net_id_q, neigh_q;
	logic        master_q, led_q;
	logic [31:0] now_q, last_m_q, last_i_q;

	assign cfg_rdata_0 = {16'd0, ask_master_q};
	assign cfg_rdata_1 = {16'd0, ask_id_q};
	assign cfg_rdata_2 = {24'd0, tile_kind_q};
	assign cfg_rdata_3 = factory_q;

	assign in_stall = cmd_full;
	logic acc;
	assign acc = in_valid && !cmd_full;

	// next-state values
	logic [2:0]  phase_n;
	logic [7:0]  hdr_type_n, hdr_target_n, hdr_length_n, pcount_n;
	logic [7:0]  net_id_n, neigh_n;
	logic        master_n, led_n;
	logic [31:0] hw_uid_n, now_n, last_m_n, last_i_n;
	logic        head_we;
	logic [CW-1:0] head_idx;
	logic        handle;
	logic [7:0]  len_eff, b;
	logic [7:0]  p0;
	logic [31:0] p_uid;
	logic [31:0] id_lim, m_lim;
	tle_pkg::frame_desc_t fr [3];
	logic [1:0]  nf;
	logic        known;

	always_comb begin
		b = in_item.byte_value;
		phase_n = phase_q; hdr_type_n = hdr_type_q; hdr_target_n = hdr_target_q;
		hdr_length_n = hdr_length_q; pcount_n = pcount_q;
		net_id_n = net_id_q; neigh_n = neigh_q; master_n = master_q; led_n = led_q;
		hw_uid_n = hw_uid_q; now_n = now_q; last_m_n = last_m_q; last_i_n = last_i_q;
		head_we = 1'b0; head_idx = pcount_q[CW-1:0]; handle = 1'b0; len_eff = hdr_length_q;
		nf = 2'd0;
		for (int i = 0; i < 3; i++) fr[i] = '0;
		known = 1'b0;
		p0 = head_q[0];
		p_uid = {head_q[0], head_q[1], head_q[2], head_q[3]};
		id_lim = 32'd0; m_lim = 32'd0;
		case (in_item.func)
			tle_pkg::FUNC_SERIAL: begin
				case (phase_q)
					3'd0: begin
						known = b inside {tle_pkg::T_GENERAL, tle_pkg::T_I_AM_MASTER,
							tle_pkg::T_I_AM_NOT_MASTER, tle_pkg::T_ARE_YOU_MASTER,
							tle_pkg::T_NEED_NID, tle_pkg::T_REPORT_HID,
							tle_pkg::T_HERE_IS_MY_NID, tle_pkg::T_HERE_IS_YOUR_NID,
							tle_pkg::T_REPORT_NEIGHBOURS, tle_pkg::T_CHANGE_HW_ID,
							tle_pkg::T_RESET_NID};
						if (known) begin
							hdr_type_n = b; phase_n = 3'd1;
						end
					end
					3'd1: begin
						hdr_target_n = b; phase_n = 3'd2;
					end
					3'd2: phase_n = 3'd3;
					3'd3: begin
						hdr_length_n = b; pcount_n = 8'd0; len_eff = b;
						if (b == 8'd0) begin
							phase_n = 3'd0; handle = 1'b1;
						end else phase_n = 3'd4;
					end
					default: begin
						if (pcount_q < 8'(KEPT)) begin
							head_we = 1'b1;
							// the byte being written now is visible to the handler
							if (pcount_q == 8'd0) p0 = b;
							if (pcount_q == 8'd3) p_uid[7:0] = b;
						end
						pcount_n = pcount_q + 8'd1;
						if (pcount_n >= hdr_length_q) begin
							phase_n = 3'd0; handle = 1'b1;
						end
					end
				endcase
				// message handling
				if (handle) begin
					if (hdr_target_q == net_id_q && net_id_q != 8'd0) begin
						if (hdr_type_q == tle_pkg::T_CHANGE_HW_ID) begin
							if (len_eff >= 8'd4) begin
								hw_uid_n = p_uid;
								fr[0] = '{1'b1, tle_pkg::FR_HID, tle_pkg::T_REPORT_HID,
									8'd1, net_id_q, 8'd0};
								nf = 2'd1;
							end
						end else if (hdr_type_q == tle_pkg::T_RESET_NID) begin
							led_n = 1'b1; net_id_n = 8'd0;
							fr[0] = '{1'b1, tle_pkg::FR_NID, tle_pkg::T_HERE_IS_MY_NID,
								8'd0, 8'd0, 8'd0};
							nf = 2'd1;
						end
					end else if (hdr_target_q == 8'd0) begin
						if (hdr_type_q == tle_pkg::T_ARE_YOU_MASTER) begin
							fr[0] = '{1'b1, tle_pkg::FR_HDR0,
								master_q ? tle_pkg::T_I_AM_MASTER : tle_pkg::T_I_AM_NOT_MASTER,
								8'd0, net_id_q, 8'd0};
							nf = 2'd1;
						end else if (hdr_type_q == tle_pkg::T_I_AM_MASTER) begin
							master_n = 1'b1;
						end else if (hdr_type_q == tle_pkg::T_HERE_IS_YOUR_NID) begin
							if (net_id_q == 8'd0 && len_eff >= 8'd1) begin
								net_id_n = p0; led_n = 1'b0;
								fr[0] = '{1'b1, tle_pkg::FR_HID, tle_pkg::T_REPORT_HID,
									8'd1, p0, 8'd0};
								fr[1] = '{1'b1, tle_pkg::FR_NID, tle_pkg::T_HERE_IS_MY_NID,
									8'd0, p0, p0};
								nf = 2'd2;
							end
						end else if (hdr_type_q == tle_pkg::T_HERE_IS_MY_NID) begin
							if (net_id_q != 8'd0 && len_eff >= 8'd1 && p0 != 8'd0
									&& p0 != neigh_q && p0 != net_id_q) begin
								neigh_n = p0;
								fr[0] = '{1'b1, tle_pkg::FR_NID, tle_pkg::T_HERE_IS_MY_NID,
									8'd0, net_id_q, net_id_q};
								fr[1] = '{1'b1, tle_pkg::FR_NEIGH, tle_pkg::T_REPORT_NEIGHBOURS,
									8'd1, net_id_q, p0};
								nf = 2'd2;
							end
						end
					end
				end
			end
			tle_pkg::FUNC_TICK: begin
				now_n = now_q + 32'd1;
				id_lim = last_i_q + {16'd0, ask_id_q};
				m_lim = last_m_q + {16'd0, ask_master_q};
				if (master_q && net_id_q == 8'd0 && now_n > id_lim) begin
					fr[0] = '{1'b1, tle_pkg::FR_HDR0, tle_pkg::T_NEED_NID, 8'd1, 8'd0, 8'd0};
					last_i_n = now_n; nf = 2'd1;
				end
				if (!master_q && now_n > m_lim && in_item.pin_level) begin
					fr[nf] = '{1'b1, tle_pkg::FR_HDR0, tle_pkg::T_ARE_YOU_MASTER,
						8'd0, net_id_q, 8'd0};
					last_m_n = now_n; nf = nf + 2'd1;
				end
				if (!in_item.pin_level && neigh_q != 8'd0) begin
					neigh_n = 8'd0;
					if (net_id_q != 8'd0 && master_q) begin
						fr[nf] = '{1'b1, tle_pkg::FR_NEIGH, tle_pkg::T_REPORT_NEIGHBOURS,
							8'd1, net_id_q, 8'd0};
						nf = nf + 2'd1;
					end
				end
			end
			tle_pkg::FUNC_RADIO: begin
				if (master_q && net_id_q != 8'd0) begin
					fr[0] = '{1'b1, tle_pkg::FR_GEN, tle_pkg::T_GENERAL, 8'd1, net_id_q, b};
					nf = 2'd1;
				end
				led_n = 1'b0;
			end
			default: ;
		endcase
		cmd.f0 = fr[0]; cmd.f1 = fr[1]; cmd.f2 = fr[2];
		cmd.uid = hw_uid_n; cmd.kind_byte = tile_kind_q; cmd.led = led_n;
		cmd_push = acc && (nf != 2'd0);
	end

	// payload head store, no reset
	always_ff @(posedge clk) begin
		if (acc && head_we) head_q[head_idx] <= b;
	end

	// config registers, parser and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ask_master_q <= tle_pkg::ASK_MASTER_RST; ask_id_q <= tle_pkg::ASK_ID_RST;
			tile_kind_q <= tle_pkg::TILE_KIND_RST; factory_q <= tle_pkg::UID_RST;
			hw_uid_q <= tle_pkg::UID_RST;
			phase_q <= '0; hdr_type_q <= '0; hdr_target_q <= '0; hdr_length_q <= '0;
			pcount_q <= '0; net_id_q <= '0; neigh_q <= '0; master_q <= 1'b0;
			led_q <= 1'b1; now_q <= '0; last_m_q <= '0; last_i_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				tle_pkg::REG_ASK_MASTER: ask_master_q <= cfg_data[15:0];
				tle_pkg::REG_ASK_ID:     ask_id_q <= cfg_data[15:0];
				tle_pkg::REG_TILE_KIND:  tile_kind_q <= cfg_data[7:0];
				tle_pkg::REG_UID: begin
					factory_q <= cfg_data; hw_uid_q <= cfg_data;
				end
				default: ;
			endcase
		end else if (acc) begin
			phase_q <= phase_n; hdr_type_q <= hdr_type_n; hdr_target_q <= hdr_target_n;
			hdr_length_q <= hdr_length_n; pcount_q <= pcount_n; net_id_q <= net_id_n;
			neigh_q <= neigh_n; master_q <= master_n; led_q <= led_n; hw_uid_q <= hw_uid_n;
			now_q <= now_n; last_m_q <= last_m_n; last_i_q <= last_i_n;
		end
	end
endmodule

// ===== rtl/tle_queue.sv =====
module tle_queue #(
	parameter int DEPTH = tle_pkg::CmdDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tle_pkg::cmd_t wdata,
	output logic          full,
	output logic          nonempty,
	input  logic          pop,
	output tle_pkg::cmd_t rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	tle_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = cnt_q == (AW+1)'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== rtl/tle_back.sv =====
module tle_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  tle_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	output tle_pkg::out_item_t out_item,
	input  logic               out_stall
);
	logic [1:0] fi_q;
	logic [3:0] bi_q;
	logic       ov_q;
	tle_pkg::out_item_t oi_q;
	tle_pkg::frame_desc_t fd;
	logic [3:0] flen;
	logic       last_frame, last_byte, load;
	logic [7:0] byt;

	assign out_valid = ov_q;
	assign out_item = oi_q;

	// pick current frame and byte
	always_comb begin
		case (fi_q)
			2'd0: fd = cmd.f0;
			2'd1: fd = cmd.f1;
			default: fd = cmd.f2;
		endcase
		flen = tle_pkg::frame_len(fd.kind);
		last_frame = (fi_q == 2'd2) || (fi_q == 2'd0 && !cmd.f1.valid)
			|| (fi_q == 2'd1 && !cmd.f2.valid);
		last_byte = bi_q == flen - 4'd1;
		case (bi_q)
			4'd0: byt = fd.ftype;
			4'd1: byt = fd.target;
			4'd2: byt = fd.sender;
			4'd3: byt = {4'd0, flen} - 8'd4;
			4'd4: byt = (fd.kind == tle_pkg::FR_HID) ? cmd.uid[31:24] : fd.data;
			4'd5: byt = (fd.kind == tle_pkg::FR_HID) ? cmd.uid[23:16] : 8'd0;
			4'd6: byt = (fd.kind == tle_pkg::FR_HID) ? cmd.uid[15:8] : 8'd0;
			4'd7: byt = (fd.kind == tle_pkg::FR_HID) ? cmd.uid[7:0] : 8'd0;
			4'd8: byt = cmd.kind_byte;
			default: byt = 8'd0;
		endcase
		load = cmd_avail && (!ov_q || !out_stall);
		cmd_pop = load && last_frame && last_byte;
	end

	// byte sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q <= '0; bi_q <= '0; ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				if (last_byte) begin
					bi_q <= '0;
					fi_q <= last_frame ? 2'd0 : fi_q + 2'd1;
				end else bi_q <= bi_q + 4'd1;
			end else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) oi_q <= '{byt, last_frame && last_byte, cmd.led};
	end
endmodule

// ===== rtl/tile_link_enumeration_engine_core.sv =====
// Link engine of one tile: the front end deframes serial bytes, runs tick timers and radio
// forwarding, and queues the frames to send; the back end streams them one byte per cycle
// while the receiver does not stall. An input item is taken when the two-entry frame queue
// has room; its output, if any, is 4 to 14 transmitted bytes, so sustained rate is set by the
// byte sequencer. The payload head store needs no clearing after reset.
module tile_link_enumeration_engine_core #(
	parameter int KEPT_PAYLOAD_BYTES = tle_pkg::KeptPayloadBytes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tle_pkg::in_item_t  in_data,
	output logic               in_stall,
	output logic               out_valid,
	output tle_pkg::out_item_t out_data,
	input  logic               out_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic cfg_we, push, full, avail, pop;
	tle_pkg::cmd_t wcmd, rcmd;
	logic [31:0] r0, r1, r2, r3;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	// register read back
	always_comb begin
		case (paddr[3:2])
			tle_pkg::REG_ASK_MASTER: prdata = r0;
			tle_pkg::REG_ASK_ID:     prdata = r1;
			tle_pkg::REG_TILE_KIND:  prdata = r2;
			default:                 prdata = r3;
		endcase
	end

	tle_front #(.KEPT(KEPT_PAYLOAD_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_item(in_data), .in_stall,
		.cfg_we, .cfg_idx(paddr[3:2]), .cfg_data(pwdata),
		.cfg_rdata_0(r0), .cfg_rdata_1(r1), .cfg_rdata_2(r2), .cfg_rdata_3(r3),
		.cmd_push(push), .cmd(wcmd), .cmd_full(full)
	);

	tle_queue u_queue (
		.clk, .arst_n, .push, .wdata(wcmd), .full, .nonempty(avail), .pop, .rdata(rcmd)
	);

	tle_back u_back (
		.clk, .arst_n, .cmd_avail(avail), .cmd(rcmd), .cmd_pop(pop),
		.out_valid, .out_item(out_data), .out_stall
	);
endmodule

// ===== rtl/tle_checker.sv =====
module tle_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input tle_pkg::out_item_t out_data,
	input logic               out_stall,
	input logic               pready
);
	// stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
	// stalled input request stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid) else $error("in hold");
	// apb never waits
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready) else $error("pready");
	// led stays constant within a burst
	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.frame_end ##1 out_valid
		|-> out_data.led_lit == $past(out_data.led_lit)) else $error("led");
	// nothing sent after reset before work
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid) else $error("rst");
endmodule

bind tile_link_enumeration_engine_core tle_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_data, .out_stall, .pready
);

// ===== tb/tle_link_checker.sv =====
module tle_link_checker
	import tle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_data,
	input  logic      in_stall,
	input  logic      out_valid,
	input  out_item_t out_data,
	input  logic      out_stall,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic      pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int        errors,
	output int        pending,
	output int        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// configuration copy
	logic [15:0] ask_master_ms, ask_id_ms;
	logic [7:0]  tile_kind;

	// link state copy
	logic [2:0]  phase;
	logic [7:0]  h_type, h_target, h_len, pl_cnt;
	logic [7:0]  pl_head [KeptPayloadBytes];
	logic [7:0]  net_id, neigh_id;
	logic        master_known, led;
	logic [31:0] uid, now_ms, last_master_ask, last_id_ask;

	logic [7:0]  tx_bytes [$];
	out_item_t   expected_bytes [$];
	int          pushed, popped;

	assign pending = pushed - popped;

	function automatic bit is_known_type(logic [7:0] b);
		return b inside {T_GENERAL, T_I_AM_MASTER, T_I_AM_NOT_MASTER, T_ARE_YOU_MASTER,
			T_NEED_NID, T_REPORT_HID, T_HERE_IS_MY_NID, T_HERE_IS_YOUR_NID,
			T_REPORT_NEIGHBOURS, T_CHANGE_HW_ID, T_RESET_NID};
	endfunction

	task automatic frame_header(logic [7:0] t, logic [7:0] tg, logic [7:0] n);
		tx_bytes.push_back(t);
		tx_bytes.push_back(tg);
		tx_bytes.push_back(net_id);
		tx_bytes.push_back(n);
	endtask

	task automatic hid_report();
		frame_header(T_REPORT_HID, 8'd1, 8'd5);
		tx_bytes.push_back(uid[31:24]);
		tx_bytes.push_back(uid[23:16]);
		tx_bytes.push_back(uid[15:8]);
		tx_bytes.push_back(uid[7:0]);
		tx_bytes.push_back(tile_kind);
	endtask

	task automatic my_nid_frame();
		frame_header(T_HERE_IS_MY_NID, 8'd0, 8'd1);
		tx_bytes.push_back(net_id);
	endtask

	task automatic neighbour_report();
		frame_header(T_REPORT_NEIGHBOURS, 8'd1, 8'd4);
		tx_bytes.push_back(neigh_id);
		repeat (3) tx_bytes.push_back(8'd0);
	endtask

	// act on a complete message
	task automatic handle_message();
		logic [7:0] id;
		if (h_target == net_id && net_id != 0) begin
			if (h_type == T_CHANGE_HW_ID) begin
				if (h_len >= 4) begin
					uid = {pl_head[0], pl_head[1], pl_head[2], pl_head[3]};
					hid_report();
				end
			end else if (h_type == T_RESET_NID) begin
				led = 1'b1;
				net_id = 0;
				my_nid_frame();
			end
		end else if (h_target == 0) begin
			if (h_type == T_ARE_YOU_MASTER) begin
				frame_header(master_known ? T_I_AM_MASTER : T_I_AM_NOT_MASTER, 8'd0, 8'd0);
			end else if (h_type == T_I_AM_MASTER) begin
				master_known = 1'b1;
			end else if (h_type == T_HERE_IS_YOUR_NID) begin
				if (net_id == 0 && h_len >= 1) begin
					net_id = pl_head[0];
					hid_report();
					led = 1'b0;
					my_nid_frame();
				end
			end else if (h_type == T_HERE_IS_MY_NID) begin
				id = pl_head[0];
				if (net_id != 0 && h_len >= 1 && id != 0 && id != neigh_id && id != net_id) begin
					my_nid_frame();
					neigh_id = id;
					neighbour_report();
				end
			end
		end
	endtask

	// deframe one serial byte
	task automatic serial_byte(logic [7:0] b);
		case (phase)
			3'd0: begin
				if (is_known_type(b)) begin
					h_type = b;
					phase = 3'd1;
				end
			end
			3'd1: begin
				h_target = b;
				phase = 3'd2;
			end
			3'd2: phase = 3'd3;
			3'd3: begin
				h_len = b;
				pl_cnt = 0;
				if (b == 0) begin
					phase = 3'd0;
					handle_message();
				end else begin
					phase = 3'd4;
				end
			end
			default: begin
				if (pl_cnt < KeptPayloadBytes)
					pl_head[pl_cnt] = b;
				pl_cnt = pl_cnt + 1;
				if (pl_cnt >= h_len) begin
					phase = 3'd0;
					handle_message();
				end
			end
		endcase
	endtask

	// millisecond tick timers and pin sampling
	task automatic ms_tick(logic pin);
		logic [31:0] due;
		now_ms = now_ms + 1;
		due = last_id_ask + 32'(ask_id_ms);
		if (master_known && net_id == 0 && now_ms > due) begin
			frame_header(T_NEED_NID, 8'd1, 8'd0);
			last_id_ask = now_ms;
		end
		due = last_master_ask + 32'(ask_master_ms);
		if (!master_known && now_ms > due && pin) begin
			frame_header(T_ARE_YOU_MASTER, 8'd0, 8'd0);
			last_master_ask = now_ms;
		end
		if (!pin && neigh_id != 0) begin
			neigh_id = 0;
			if (net_id != 0 && master_known)
				neighbour_report();
		end
	endtask

	// expected output bytes for one request
	task automatic predict_link(in_item_t it);
		out_item_t e;
		tx_bytes.delete();
		case (it.func)
			FUNC_SERIAL: serial_byte(it.byte_value);
			FUNC_TICK:   ms_tick(it.pin_level);
			FUNC_RADIO: begin
				if (master_known && net_id != 0) begin
					frame_header(T_GENERAL, 8'd1, 8'd1);
					tx_bytes.push_back(it.byte_value);
				end
				led = 1'b0;
			end
			default: ;
		endcase
		foreach (tx_bytes[k]) begin
			if (k < MaxOut) begin
				e.tx_byte = tx_bytes[k];
				e.frame_end = (k == tx_bytes.size() - 1 || k == MaxOut - 1);
				e.led_lit = led;
				expected_bytes.push_back(e);
				pushed++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			ask_master_ms = ASK_MASTER_RST;
			ask_id_ms = ASK_ID_RST;
			tile_kind = TILE_KIND_RST;
			uid = UID_RST;
			phase = 0;
			h_type = 0;
			h_target = 0;
			h_len = 0;
			pl_cnt = 0;
			foreach (pl_head[i]) pl_head[i] = 0;
			net_id = 0;
			neigh_id = 0;
			master_known = 0;
			led = 1'b1;
			now_ms = 0;
			last_master_ask = 0;
			last_id_ask = 0;
			expected_bytes.delete();
			pushed = 0;
			popped = 0;
			errors = 0;
			checked = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ASK_MASTER: ask_master_ms = pwdata[15:0];
					REG_ASK_ID:     ask_id_ms = pwdata[15:0];
					REG_TILE_KIND:  tile_kind = pwdata[7:0];
					REG_UID:        uid = pwdata;
				endcase
			end
			if (in_valid && !in_stall)
				predict_link(in_data);
			// compare transmitted bytes
			if (out_valid && !out_stall) begin
				checked++;
				if (expected_bytes.size() == 0) begin
					$error("unexpected output byte %0h", out_data.tx_byte);
					errors++;
				end else begin
					e = expected_bytes.pop_front();
					popped++;
					if (out_data.tx_byte !== e.tx_byte) begin
						$error("tx_byte expected %0h actual %0h", e.tx_byte, out_data.tx_byte);
						errors++;
					end
					if (out_data.frame_end !== e.frame_end) begin
						$error("frame_end expected %0b actual %0b", e.frame_end,
							out_data.frame_end);
						errors++;
					end
					if (out_data.led_lit !== e.led_lit) begin
						$error("led_lit expected %0b actual %0b", e.led_lit, out_data.led_lit);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_tile_link_enumeration_engine_core.sv =====
module tb_tile_link_enumeration_engine_core;
	import tle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	in_item_t    in_data;
	logic        in_stall;
	logic        out_valid;
	out_item_t   out_data;
	logic        out_stall = 1'b0;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          errors, pending, checked;

	int          send_idle_pct, stall_pct;
	int          items_sent;
	bit          hold_req, hold_seen;
	int          hold_left;

	logic [7:0]  type_list [11] = '{T_GENERAL, T_I_AM_MASTER, T_I_AM_NOT_MASTER,
		T_ARE_YOU_MASTER, T_NEED_NID, T_REPORT_HID, T_HERE_IS_MY_NID, T_HERE_IS_YOUR_NID,
		T_REPORT_NEIGHBOURS, T_CHANGE_HW_ID, T_RESET_NID};

	tile_link_enumeration_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tle_link_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall, with one long hold-off in the first random phase
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#3ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// offer one request and wait for it to be taken
	task automatic send(logic [1:0] f, logic [7:0] b, logic pin, bit counted = 1);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: f, byte_value: b, pin_level: pin};
		do @(posedge clk); while (in_stall);
		if (counted) items_sent++;
	endtask

	task automatic send_frame(logic [7:0] t, logic [7:0] tg, logic [7:0] n,
		logic [63:0] pl = '0);
		send(FUNC_SERIAL, t, $urandom_range(1));
		send(FUNC_SERIAL, tg, $urandom_range(1));
		send(FUNC_SERIAL, 8'($urandom_range(255)), $urandom_range(1));
		send(FUNC_SERIAL, n, $urandom_range(1));
		for (int k = 0; k < n; k++)
			send(FUNC_SERIAL, (k < 8) ? pl[8*k +: 8] : 8'($urandom_range(255)),
				$urandom_range(1));
	endtask

	// stop offering and let every expected byte come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one random piece of traffic, about half the time a whole frame
	task automatic random_traffic();
		int pick, n;
		logic [7:0] tg;
		logic [63:0] pl;
		pick = $urandom_range(99);
		if (pick < 50) begin
			case ($urandom_range(3))
				0, 3: tg = 0;
				1: tg = 8'($urandom_range(1, 6));
				default: tg = 8'($urandom_range(255));
			endcase
			n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
			pl = {$urandom, $urandom};
			if ($urandom_range(3) != 0) pl[7:0] = 8'($urandom_range(0, 6));
			send_frame(type_list[$urandom_range(10)], tg, 8'(n), pl);
		end else if (pick < 78) begin
			send(FUNC_TICK, 8'($urandom_range(255)), $urandom_range(3) != 0);
		end else if (pick < 88) begin
			send(FUNC_RADIO, 8'($urandom_range(255)), $urandom_range(1));
		end else if (pick < 93) begin
			send(FUNC_SERIAL, 8'($urandom_range(255)), $urandom_range(1));
		end else if (pick < 96) begin
			send(2'd3, 8'($urandom_range(255)), $urandom_range(1), 0);
		end else begin
			// header cut short, later serial bytes complete its header and payload
			send(FUNC_SERIAL, type_list[$urandom_range(10)], 1'b1);
			send(FUNC_SERIAL, 8'd0, 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_ASK_MASTER, 32'd0);
		reg_write(REG_ASK_ID, 32'd0);
		reg_write(REG_TILE_KIND, 32'hFF);
		reg_write(REG_UID, 32'hFFFF_FFFF);

		// directed: master discovery, id assignment, neighbours, radio, id changes, id reset
		send(FUNC_TICK, 8'h00, 1'b1);
		send_frame(T_ARE_YOU_MASTER, 8'd0, 8'd0);
		send_frame(T_I_AM_MASTER, 8'd0, 8'd0);
		send(FUNC_TICK, 8'hFF, 1'b1);
		send_frame(T_HERE_IS_YOUR_NID, 8'd0, 8'd0);
		send_frame(T_HERE_IS_YOUR_NID, 8'd0, 8'd1, 64'hFF);
		send_frame(T_HERE_IS_MY_NID, 8'd0, 8'd2, 64'h3307);
		send(FUNC_TICK, 8'h00, 1'b0);
		send(FUNC_RADIO, 8'hA5, 1'b0);
		send(FUNC_RADIO, 8'h5A, 1'b1);
		send_frame(T_CHANGE_HW_ID, 8'hFF, 8'd6, 64'hAB89_6745_2301);
		send_frame(T_CHANGE_HW_ID, 8'hFF, 8'd3, 64'h123456);
		send(FUNC_SERIAL, 8'h00, 1'b0, 0);
		send(2'd3, 8'hFF, 1'b1, 0);
		send_frame(T_RESET_NID, 8'hFF, 8'd0);
		drain();

		// random phases with different idling and receiver stalling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 77; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 77; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			if (ph == 2) begin
				reg_write(REG_ASK_MASTER, 32'hFFFF);
				reg_write(REG_ASK_ID, 32'hFFFF);
				reg_write(REG_TILE_KIND, 32'h00);
				reg_write(REG_UID, 32'h0);
			end else if (ph == 3) begin
				reg_write(REG_ASK_MASTER, $urandom_range(0, 5));
				reg_write(REG_ASK_ID, $urandom_range(0, 20));
				reg_write(REG_TILE_KIND, $urandom_range(255));
				reg_write(REG_UID, $urandom);
			end
			if (ph == 0) hold_req = ~hold_req;
			while (items_sent < 30 + 50 * (ph + 1)) random_traffic();
			drain();
		end

		$display("covered %0d requests and %0d output bytes over four idling phases",
			items_sent, checked);
		$display("register extremes, master and id discovery, neighbours and radio exercised");
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tle_pkg.sv
rtl/tle_front.sv
rtl/tle_queue.sv
rtl/tle_back.sv
rtl/tile_link_enumeration_engine_core.sv
rtl/tle_checker.sv
tb/tle_link_checker.sv
tb/tb_tile_link_enumeration_engine_core.sv
